/* src/dbrs_pkg.sv */
// ----------------------------------------------------------------------------
// dbrs_pkg
// Shared types and constants for the DAC bias ramp stepper.
// ----------------------------------------------------------------------------
package dbrs_pkg;

    localparam int NUM_CHANNELS_DEF = 32;

    localparam int LEVEL_W = 16;
    localparam int CHAN_W  = 6;
    localparam int MCHAN_W = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // shared divider: 32-bit dividend, 16-bit divisor
    localparam int DVD_W = 32;
    localparam int DSR_W = 16;

    localparam int STEP_W = 18;
    localparam int STOP_W = 19;
    localparam int QSAT_W = 17;
    localparam int PROD_W = 36;

    localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_LEVEL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_CHANNEL = 3'd6;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_START  = 2'd1,
        OP_MANUAL = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP_DIV,
        S_Q_DIV,
        S_MUL,
        S_CLAMP,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* src/dbrs_div.sv */
// ----------------------------------------------------------------------------
// dbrs_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dbrs_div
    import dbrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output div_status_t      status
);

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic             run_reg,  run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [DSR_W-1:0] rem_reg,  rem_next;
    logic [DSR_W-1:0] dsr_reg,  dsr_next;
    logic [DVD_W-1:0] quo_reg,  quo_next;

    logic [DSR_W:0] shifted;
    logic [DSR_W:0] diff;
    logic           fits;

    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            dsr_next = divisor;
            quo_next = dividend;
        end
        else if (run_reg)
        begin
            // remainder stays below the divisor, so DSR_W bits hold it
            rem_next = fits ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = run_reg;
    assign status.done = done_reg;

endmodule

/* src/dac_bias_ramp_stepper.sv */
// ----------------------------------------------------------------------------
// dac_bias_ramp_stepper
// Staircase ramp generator for one DAC bus.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): op, manual_level, manual_channel.
//   op 0 is a tick, 1 arms the ramp, 2 writes one manual level.
//   Output channel (out_valid/out_ready): level, channel, ramp_active.
//   Registers are written through cfg_write/cfg_index/cfg_data while idle;
//   the user must see to it, as the block does not enforce it. Start items,
//   unknown ops, ticks with no ramp running and manual sets to a channel
//   out of range leave the sequencer idle and give no result. A manual set
//   goes through S_EMIT into the output register. A tick of a running ramp
//   uses one shared restoring divider (the step size on the first tick, the
//   tick/dwell quotient on later ticks), then a multiply and a clamp stage.
//   The block takes one item at a time; in_ready is high when the sequencer
//   is idle. A finished result sits in the output register, so the next item
//   is accepted while it waits; a stalled receiver only holds a later result.
//   Reset clears the ramp, loads the register defaults and leaves the output
//   empty. No memory clearing pass is needed.
// ----------------------------------------------------------------------------
module dac_bias_ramp_stepper
    import dbrs_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            op,
    input  logic [LEVEL_W-1:0]    manual_level,
    input  logic [MCHAN_W-1:0]    manual_channel,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LEVEL_W-1:0]    level,
    output logic [CHAN_W-1:0]     channel,
    output logic                  ramp_active
);

    localparam logic [6:0]        NCH7     = 7'(NUM_CHANNELS);
    localparam logic [CHAN_W-1:0] ALL_CHAN = CHAN_W'(NUM_CHANNELS);

    // configuration
    logic [LEVEL_W-1:0] start_level_reg, end_level_reg, step_count_reg;
    logic [LEVEL_W-1:0] dwell_ticks_reg, lower_limit_reg, upper_limit_reg;
    logic [CHAN_W-1:0]  target_channel_reg;

    // sequencer and ramp state
    state_t state_reg, state_next;
    logic                     running_reg,    running_next;
    logic [DVD_W-1:0]         tick_index_reg, tick_index_next;
    logic signed [STEP_W-1:0] step_reg,       step_next;
    logic signed [STOP_W-1:0] stop_reg,       stop_next;
    logic [LEVEL_W-1:0]       held_start_reg, held_start_next;
    logic [DSR_W-1:0]         held_dwell_reg, held_dwell_next;
    logic                     diff_neg_reg,   diff_neg_next;
    logic [QSAT_W-1:0]        q_sat_reg,      q_sat_next;
    logic signed [PROD_W-1:0] prod_reg,       prod_next;
    logic [LEVEL_W-1:0]       pend_level_reg, pend_level_next;
    logic [CHAN_W-1:0]        pend_chan_reg,  pend_chan_next;
    logic                     pend_active_reg, pend_active_next;
    logic                     out_valid_reg,  out_valid_next;
    logic [LEVEL_W-1:0]       level_reg,      level_next;
    logic [CHAN_W-1:0]        channel_reg,    channel_next;
    logic                     ramp_active_reg, ramp_active_next;

    // divider hookup
    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DSR_W-1:0] div_divisor;
    logic [DVD_W-1:0] div_quotient;
    div_status_t      div_st;

    logic                 accept_in;
    logic                 out_free;
    logic                 manual_ok;
    logic signed [16:0]   diff;
    logic [LEVEL_W-1:0]   diff_mag;
    logic [DSR_W-1:0]     count_nz;
    logic [DSR_W-1:0]     dwell_nz;
    logic [LEVEL_W-1:0]   q_mag;
    logic signed [STEP_W-1:0] step_calc;
    logic signed [PROD_W-1:0] v_raw;
    logic [LEVEL_W-1:0]   v_hi;
    logic [LEVEL_W-1:0]   v_cl;
    logic signed [19:0]   v_cmp;
    logic signed [19:0]   stop_cmp;
    logic                 stop_hit;
    logic [CHAN_W-1:0]    ramp_chan;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept_in = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign manual_ok = {2'b00, manual_channel} < NCH7;

    assign diff     = $signed({1'b0, end_level_reg}) - $signed({1'b0, start_level_reg});
    assign diff_mag = diff[16] ? LEVEL_W'(-diff) : diff[LEVEL_W-1:0];
    assign count_nz = (step_count_reg == '0) ? DSR_W'(1) : step_count_reg;
    assign dwell_nz = (dwell_ticks_reg == '0) ? DSR_W'(1) : dwell_ticks_reg;

    // truncated step with magnitude of at least one
    assign q_mag = div_quotient[LEVEL_W-1:0];
    always_comb
    begin
        if (q_mag == '0)
            step_calc = diff_neg_reg ? -STEP_W'(1) : STEP_W'(1);
        else if (diff_neg_reg)
            step_calc = -$signed({2'b00, q_mag});
        else
            step_calc = $signed({2'b00, q_mag});
    end

    // a quotient past 17 bits clamps to a limit anyway
    assign v_raw = $signed({20'd0, held_start_reg}) + prod_reg;
    assign v_hi  = (v_raw > $signed({20'd0, upper_limit_reg})) ? upper_limit_reg
                                                              : v_raw[LEVEL_W-1:0];
    assign v_cl  = (v_raw > $signed({20'd0, upper_limit_reg}) ? upper_limit_reg < lower_limit_reg
                                                              : v_raw < $signed({20'd0, lower_limit_reg}))
                   ? lower_limit_reg : v_hi;
    assign v_cmp    = $signed({4'd0, v_cl});
    assign stop_cmp = 20'(stop_reg);
    assign stop_hit = step_reg[STEP_W-1]
                      ? (v_cmp <= stop_cmp || v_cl <= lower_limit_reg)
                      : (v_cmp >= stop_cmp || v_cl >= upper_limit_reg);

    assign ramp_chan = ({1'b0, target_channel_reg} < NCH7) ? target_channel_reg : ALL_CHAN;

    dbrs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_st)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    case (op)
                        OP_TICK:
                        begin
                            if (running_reg)
                                state_next = (tick_index_reg == '0) ? S_STEP_DIV : S_Q_DIV;
                        end
                        OP_MANUAL:
                        begin
                            if (manual_ok)
                                state_next = S_EMIT;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_STEP_DIV: if (div_st.done) state_next = S_MUL;
            S_Q_DIV:    if (div_st.done) state_next = S_MUL;
            S_MUL:      state_next = S_CLAMP;
            S_CLAMP:    state_next = S_EMIT;
            S_EMIT:     if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        running_next     = running_reg;
        tick_index_next  = tick_index_reg;
        step_next        = step_reg;
        stop_next        = stop_reg;
        held_start_next  = held_start_reg;
        held_dwell_next  = held_dwell_reg;
        diff_neg_next    = diff_neg_reg;
        q_sat_next       = q_sat_reg;
        prod_next        = prod_reg;
        pend_level_next  = pend_level_reg;
        pend_chan_next   = pend_chan_reg;
        pend_active_next = pend_active_reg;
        level_next       = level_reg;
        channel_next     = channel_reg;
        ramp_active_next = ramp_active_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        div_start        = 1'b0;
        div_dividend     = tick_index_reg;
        div_divisor      = held_dwell_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    case (op)
                        OP_TICK:
                        begin
                            if (!running_reg)
                                tick_index_next = '0;
                            else if (tick_index_reg == '0)
                            begin
                                div_start       = 1'b1;
                                div_dividend    = {{(DVD_W-LEVEL_W){1'b0}}, diff_mag};
                                div_divisor     = count_nz;
                                diff_neg_next   = diff[16];
                                held_start_next = start_level_reg;
                                held_dwell_next = dwell_nz;
                            end
                            else
                                div_start = 1'b1;
                        end
                        OP_START:
                        begin
                            running_next    = 1'b1;
                            tick_index_next = '0;
                        end
                        OP_MANUAL:
                        begin
                            running_next     = 1'b0;
                            tick_index_next  = '0;
                            pend_level_next  = manual_level;
                            pend_chan_next   = {1'b0, manual_channel};
                            pend_active_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_STEP_DIV:
            begin
                if (div_st.done)
                begin
                    step_next  = step_calc;
                    stop_next  = $signed({3'b000, end_level_reg}) + STOP_W'(step_calc);
                    q_sat_next = '0;
                end
            end
            S_Q_DIV:
            begin
                if (div_st.done)
                    q_sat_next = (div_quotient[DVD_W-1:QSAT_W] != '0) ? '1
                                                                       : div_quotient[QSAT_W-1:0];
            end
            S_MUL:
                prod_next = PROD_W'($signed({1'b0, q_sat_reg}) * step_reg);
            S_CLAMP:
            begin
                tick_index_next  = tick_index_reg + 1'b1;
                running_next     = !stop_hit;
                pend_level_next  = v_cl;
                pend_chan_next   = ramp_chan;
                pend_active_next = !stop_hit;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    level_next       = pend_level_reg;
                    channel_next     = pend_chan_reg;
                    ramp_active_next = pend_active_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_level_reg    <= '0;
            end_level_reg      <= '0;
            step_count_reg     <= LEVEL_W'(1);
            dwell_ticks_reg    <= LEVEL_W'(1);
            lower_limit_reg    <= '0;
            upper_limit_reg    <= '1;
            target_channel_reg <= ALL_CHAN;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_START_LEVEL:    start_level_reg    <= cfg_data;
                REG_END_LEVEL:      end_level_reg      <= cfg_data;
                REG_STEP_COUNT:     step_count_reg     <= cfg_data;
                REG_DWELL_TICKS:    dwell_ticks_reg    <= cfg_data;
                REG_LOWER_LIMIT:    lower_limit_reg    <= cfg_data;
                REG_UPPER_LIMIT:    upper_limit_reg    <= cfg_data;
                REG_TARGET_CHANNEL: target_channel_reg <= cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            running_reg    <= 1'b0;
            tick_index_reg <= '0;
            step_reg       <= STEP_W'(1);
            stop_reg       <= '0;
            held_start_reg <= '0;
            held_dwell_reg <= DSR_W'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            running_reg    <= running_next;
            tick_index_reg <= tick_index_next;
            step_reg       <= step_next;
            stop_reg       <= stop_next;
            held_start_reg <= held_start_next;
            held_dwell_reg <= held_dwell_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_neg_reg    <= diff_neg_next;
        q_sat_reg       <= q_sat_next;
        prod_reg        <= prod_next;
        pend_level_reg  <= pend_level_next;
        pend_chan_reg   <= pend_chan_next;
        pend_active_reg <= pend_active_next;
        level_reg       <= level_next;
        channel_reg     <= channel_next;
        ramp_active_reg <= ramp_active_next;
    end

    assign out_valid   = out_valid_reg;
    assign level       = level_reg;
    assign channel     = channel_reg;
    assign ramp_active = ramp_active_reg;

    // divider completes only while the sequencer waits on it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == S_STEP_DIV || state_reg == S_Q_DIV))
        else $error("divider finished outside a divide state");

    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != '0)
        else $error("ramp step is zero");

    a_dwell_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        held_dwell_reg != '0)
        else $error("held dwell is zero");

    a_idle_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && op == OP_TICK && !running_reg) |=> (tick_index_reg == '0))
        else $error("idle tick left the tick index nonzero");

endmodule
